### rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each macro expects clk_i and rst_ni in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sitda_pkg.sv
`timescale 1ns / 1ps

package sitda_pkg;

  // Width of the signed input value.
  localparam int ValueBits = 32;

  // Decimal digits needed for the largest magnitude, 2^(ValueBits-1).
  localparam int NumDigits = ((ValueBits - 1) * 30103) / 100000 + 1;
  localparam int BcdBits   = NumDigits * 4;

  // Counter widths for the conversion and emission loops.
  localparam int BitCntW = $clog2(ValueBits + 1);
  localparam int DigCntW = $clog2(NumDigits + 1);

  // Stream payload widths, padded to whole bytes.
  localparam int CharBits = 8;
  localparam int InDataW  = ((ValueBits + 7) / 8) * 8;

  // Character codes.
  localparam logic [CharBits-1:0] CharZero  = 8'd48;
  localparam logic [CharBits-1:0] CharMinus = 8'd45;

  // Finished conversion handed from the converter to the emitter.
  typedef struct packed {
    logic               valid;
    logic               neg;
    logic [BcdBits-1:0] bcd;
  } dab_res_t;

endpackage

### rtl/sitda_dabble.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module sitda_dabble (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           neg_i,
  input  logic [sitda_pkg::ValueBits-1:0] mag_i,
  output logic                           idle_o,
  output sitda_pkg::dab_res_t            res_o,
  input  logic                           take_i
);

  localparam logic [1:0] DbIdle = 2'd0;
  localparam logic [1:0] DbRun  = 2'd1;
  localparam logic [1:0] DbDone = 2'd2;

  logic [1:0]                       st_q, st_d;
  logic [sitda_pkg::BitCntW-1:0]    cnt_q, cnt_d;
  logic [sitda_pkg::ValueBits-1:0]  mag_q, mag_d;
  logic [sitda_pkg::BcdBits-1:0]    bcd_q, bcd_d;
  logic [sitda_pkg::BcdBits-1:0]    corr;
  logic                             neg_q, neg_d;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      if (bcd_q[i*4 +: 4] inside {[4'd5:4'd15]}) begin
        corr[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        corr[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Sequencer: load, shift ValueBits times, then hold the result.
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    mag_d = mag_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    case (st_q)
      DbIdle: begin
        if (start_i) begin
          mag_d = mag_i;
          neg_d = neg_i;
          bcd_d = '0;
          cnt_d = '0;
          st_d  = DbRun;
        end
      end
      DbRun: begin
        bcd_d = {corr[sitda_pkg::BcdBits-2:0], mag_q[sitda_pkg::ValueBits-1]};
        mag_d = {mag_q[sitda_pkg::ValueBits-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sitda_pkg::BitCntW'(sitda_pkg::ValueBits - 1)) begin
          st_d = DbDone;
        end
      end
      DbDone: begin
        if (take_i) begin
          st_d = DbIdle;
        end
      end
      default: st_d = DbIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= DbIdle;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign idle_o       = (st_q == DbIdle);
  assign res_o.valid  = (st_q == DbDone);
  assign res_o.neg    = neg_q;
  assign res_o.bcd    = bcd_q;

  `ASSERT_IMPLIES(a_cnt_range, st_q == DbRun,
    cnt_q < sitda_pkg::BitCntW'(sitda_pkg::ValueBits), "shift count ran past the width")
  `ASSERT_NEXT(a_start_runs, st_q == DbIdle && start_i, st_q == DbRun && cnt_q == '0,
    "start did not begin a conversion")

endmodule

### rtl/sitda_emit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Emits the sign and the digits one beat at a time through an output register.
module sitda_emit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sitda_pkg::dab_res_t               res_i,
  output logic                              take_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [sitda_pkg::CharBits-1:0]    m_char_o,
  output logic                              m_last_o
);

  localparam logic [1:0] EmIdle = 2'd0;
  localparam logic [1:0] EmSign = 2'd1;
  localparam logic [1:0] EmDig  = 2'd2;

  logic [1:0]                        st_q, st_d;
  logic [sitda_pkg::BcdBits-1:0]     sh_q, sh_d;
  logic [sitda_pkg::DigCntW-1:0]     left_q, left_d;
  logic                              started_q, started_d;
  logic                              ovalid_q, ovalid_d;
  logic [sitda_pkg::CharBits-1:0]    ochar_q, ochar_d;
  logic                              olast_q, olast_d;
  logic [3:0]                        top;
  logic                              out_free;
  logic                              emit;
  logic [sitda_pkg::CharBits-1:0]    emit_char;
  logic                              emit_last;

  assign top      = sh_q[sitda_pkg::BcdBits-1 -: 4];
  assign out_free = !ovalid_q || m_ready_i;
  assign take_o   = (st_q == EmIdle) && res_i.valid;

  // Walk the digits from the top, dropping leading zeros but keeping the units digit.
  always_comb begin
    st_d      = st_q;
    sh_d      = sh_q;
    left_d    = left_q;
    started_d = started_q;
    emit      = 1'b0;
    emit_char = sitda_pkg::CharZero;
    emit_last = 1'b0;
    case (st_q)
      EmIdle: begin
        if (res_i.valid) begin
          sh_d      = res_i.bcd;
          left_d    = sitda_pkg::DigCntW'(sitda_pkg::NumDigits);
          started_d = 1'b0;
          st_d      = res_i.neg ? EmSign : EmDig;
        end
      end
      EmSign: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = sitda_pkg::CharMinus;
          st_d      = EmDig;
        end
      end
      EmDig: begin
        if (top == 4'd0 && left_q > sitda_pkg::DigCntW'(1) && !started_q) begin
          sh_d   = {sh_q[sitda_pkg::BcdBits-5:0], 4'd0};
          left_d = left_q - 1'b1;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_char = sitda_pkg::CharZero + {4'd0, top};
          emit_last = (left_q == sitda_pkg::DigCntW'(1));
          sh_d      = {sh_q[sitda_pkg::BcdBits-5:0], 4'd0};
          left_d    = left_q - 1'b1;
          started_d = 1'b1;
          if (left_q == sitda_pkg::DigCntW'(1)) begin
            st_d = EmIdle;
          end
        end
      end
      default: st_d = EmIdle;
    endcase
  end

  // Output register: loads a new beat whenever the old one is gone or leaving.
  always_comb begin
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (emit) begin
      ovalid_d = 1'b1;
      ochar_d  = emit_char;
      olast_d  = emit_last;
    end else if (m_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= EmIdle;
      left_q    <= '0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      st_q      <= st_d;
      left_q    <= left_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign m_valid_o = ovalid_q;
  assign m_char_o  = ochar_q;
  assign m_last_o  = olast_q;

  `ASSERT_IMPLIES(a_sign_not_last, ovalid_q && ochar_q == sitda_pkg::CharMinus,
    !olast_q, "minus sign marked as last")
  `ASSERT_IMPLIES(a_dig_left, st_q == EmDig, left_q != '0, "digit walk with no digits left")

endmodule

### rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text.
// Slave channel: one beat carries a signed two's complement value in
// s_axis_tdata_i. Master channel: one beat per character of its decimal text,
// most significant first, with a leading '-' for negative values; tlast marks
// the final character. Zero gives the single character '0'.
// Conversion: the bit-serial shift-and-add-three converter shifts in one bit
// per cycle, then hands its result to the emitter, which walks the digits and
// loads the first character into the output register. Leading zero digits
// are dropped at one per cycle, and the characters then follow one per cycle
// while the receiver accepts them. The rate of values is set by the converter,
// which takes a new value only when idle and frees as soon as the emitter has
// taken its result; emission of one value overlaps conversion of the next.
// Reset clears both stages and the output register; no beat is pending after
// reset. When the receiver stalls, the current beat holds in the output
// register, the emitter waits, and the converter holds its finished result,
// so s_axis_tready_o stays low until space frees up.
module signed_int_to_decimal_ascii (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [sitda_pkg::InDataW-1:0]   s_axis_tdata_i,   // [31:0] value
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [sitda_pkg::CharBits-1:0]  m_axis_tdata_o,   // [7:0] char_code
  output logic                            m_axis_tlast_o    // last
);

  logic [sitda_pkg::ValueBits-1:0] value;
  logic [sitda_pkg::ValueBits-1:0] mag;
  logic                            neg;
  logic                            start;
  logic                            take;
  sitda_pkg::dab_res_t             res;

  // Sign and magnitude; the most negative value wraps to its unsigned magnitude.
  assign value = s_axis_tdata_i[sitda_pkg::ValueBits-1:0];
  assign neg   = value[sitda_pkg::ValueBits-1];
  assign mag   = neg ? (~value + 1'b1) : value;
  assign start = s_axis_tvalid_i && s_axis_tready_o;

  sitda_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .neg_i   (neg),
    .mag_i   (mag),
    .idle_o  (s_axis_tready_o),
    .res_o   (res),
    .take_i  (take)
  );

  sitda_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .take_o    (take),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_char_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule
